### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the dead-reckoning block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication, disabled while reset is held.
`define IDR_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define IDR_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/idr_pkg.sv
// ----------------------------------------------------------------------------
// idr_pkg
// Widths, constants, types and helper functions of the dead-reckoning block.
// ----------------------------------------------------------------------------
package idr_pkg;

    localparam int ACC_W  = 32;   // acceleration, Q16.16
    localparam int ANG_W  = 16;   // angle, Q3.13
    localparam int DT_W   = 24;   // time step, Q0.24
    localparam int POS_W  = 48;   // velocity and position, Q24.24
    localparam int CS_W   = 33;   // CORDIC x and y, Q2.30 with headroom
    localparam int Z_W    = 21;   // CORDIC angle accumulator, Q16
    localparam int MAT_W  = 34;   // matrix entries and partial products, Q2.30
    localparam int NPROD  = 14;   // products needed to build the matrix
    localparam int NMAT   = 9;

    localparam logic [DT_W-1:0]          DT_RESET    = 24'd16777;
    localparam logic signed [CS_W-1:0]   CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [Z_W-1:0]    PI_Q16      = 21'sd205887;
    localparam logic signed [Z_W-1:0]    HALF_PI_Q16 = 21'sd102944;

    typedef enum logic [1:0] {
        T_IDLE,
        T_LANES,
        T_MERGE
    } t_top_state;

    typedef enum logic [2:0] {
        M_IDLE,
        M_MAT,
        M_SUM,
        M_ROT_A,
        M_ROT_B,
        M_DONE
    } t_mrg_state;

    typedef struct packed {
        logic signed [CS_W-1:0] cos_v;
        logic signed [CS_W-1:0] sin_v;
    } t_sincos;

    typedef struct packed {
        logic start;
        logic take;
    } t_mrg_ctl;

    // Arctangent of 2^-i in Q16.
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] idx);
        logic signed [Z_W-1:0] v;
        case (idx)
            4'd0:    v = 21'sd51472;
            4'd1:    v = 21'sd30386;
            4'd2:    v = 21'sd16055;
            4'd3:    v = 21'sd8150;
            4'd4:    v = 21'sd4091;
            4'd5:    v = 21'sd2047;
            4'd6:    v = 21'sd1024;
            4'd7:    v = 21'sd512;
            4'd8:    v = 21'sd256;
            4'd9:    v = 21'sd128;
            4'd10:   v = 21'sd64;
            4'd11:   v = 21'sd32;
            4'd12:   v = 21'sd16;
            4'd13:   v = 21'sd8;
            4'd14:   v = 21'sd4;
            4'd15:   v = 21'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Clamp a 56-bit signed value to the signed 48-bit range.
    function automatic logic signed [POS_W-1:0] sat48(input logic signed [55:0] v);
        logic signed [POS_W-1:0] r;
        if (v > $signed({8'h00, 48'h7FFF_FFFF_FFFF})) begin
            r = 48'sh7FFF_FFFF_FFFF;
        end else if (v < $signed({8'hFF, 48'h8000_0000_0000})) begin
            r = 48'sh8000_0000_0000;
        end else begin
            r = v[POS_W-1:0];
        end
        return r;
    endfunction

endpackage

### src/idr_if.sv
// ----------------------------------------------------------------------------
// idr_if
// Valid/ready channels of the dead-reckoning block: sample in, position out.
// ----------------------------------------------------------------------------
interface idr_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [15:0] yaw_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] roll_angle;

    modport source (output valid, accel_x, accel_y, accel_z,
                    yaw_angle, pitch_angle, roll_angle, input ready);
    modport sink   (input valid, accel_x, accel_y, accel_z,
                    yaw_angle, pitch_angle, roll_angle, output ready);
endinterface

interface idr_out_if;
    logic               valid;
    logic               ready;
    logic signed [47:0] position_x;
    logic signed [47:0] position_y;
    logic signed [47:0] position_z;

    modport source (output valid, position_x, position_y, position_z, input ready);
    modport sink   (input valid, position_x, position_y, position_z, output ready);
endinterface

### src/imu_dead_reckoning_step.sv
// ----------------------------------------------------------------------------
// imu_dead_reckoning_step
// Inertial dead reckoning: body velocity update, Euler rotation of the step
// displacement and world position accumulation, one position per sample.
// ----------------------------------------------------------------------------
// Channel   Dir  Payload                                     Handshake
// i_in      in   accel_x/y/z Q16.16, yaw/pitch/roll Q3.13    valid/ready
// o_out     out  position_x/y/z Q24.24, saturated            valid/ready
// i_cfg     in   time_step Q0.24                             i_cfg_we
//
// A sample passes through the CORDIC lanes (start plus 16 iterations), the 14
// matrix products on one shared multiplier, the matrix sums, the nine split
// rotation products and the load of the output register. The next sample is
// accepted only once the result has been loaded into the output register, so
// the block does not take a new sample before the last one is through.
// Reset is synchronous and active low; it clears velocity and position and
// loads the default time step. A waiting result sits in the output register,
// so the next sample is taken while the result is stalled.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module imu_dead_reckoning_step (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [idr_pkg::DT_W-1:0]       i_cfg_wdata,
    idr_in_if.sink                         i_in,
    idr_out_if.source                      o_out
);
    import idr_pkg::*;

    t_top_state               r_state;
    t_top_state               n_state;
    logic [DT_W-1:0]          r_dt;
    logic                     r_out_valid;
    logic signed [POS_W-1:0]  r_out_pos [3];

    logic                     accept;
    logic                     lane_start;
    logic                     lanes_done;
    logic [2:0]               axis_done;
    logic [2:0]               ang_done;
    logic signed [POS_W-1:0]  disp [3];
    logic signed [ACC_W-1:0]  accel [3];
    logic signed [ANG_W-1:0]  angle [3];
    t_sincos                  sc [3];
    t_mrg_ctl                 mrg_ctl;
    logic                     mrg_done;
    logic signed [POS_W-1:0]  mrg_pos [3];

    assign accel[0] = i_in.accel_x;
    assign accel[1] = i_in.accel_y;
    assign accel[2] = i_in.accel_z;
    assign angle[0] = i_in.yaw_angle;
    assign angle[1] = i_in.pitch_angle;
    assign angle[2] = i_in.roll_angle;

    // Time step register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt <= DT_RESET;
        end else if (i_cfg_we) begin
            r_dt <= i_cfg_wdata;
        end
    end

    // Axis and angle lanes run side by side.
    for (genvar g = 0; g < 3; g++) begin : g_lane
        idr_axis_lane u_axis (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (lane_start),
            .i_accel (accel[g]),
            .i_dt    (r_dt),
            .o_done  (axis_done[g]),
            .o_disp  (disp[g])
        );
        idr_cordic_lane u_cordic (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (lane_start),
            .i_angle (angle[g]),
            .o_done  (ang_done[g]),
            .o_sc    (sc[g])
        );
    end

    idr_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mrg_ctl),
        .i_disp  (disp),
        .i_yaw   (sc[0]),
        .i_pitch (sc[1]),
        .i_roll  (sc[2]),
        .o_done  (mrg_done),
        .o_pos   (mrg_pos)
    );

    assign lanes_done = (&axis_done) & (&ang_done);
    assign accept     = i_in.valid & i_in.ready;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= T_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencing of lanes, merge and output register.
    always_comb begin
        n_state       = r_state;
        i_in.ready    = 1'b0;
        lane_start    = 1'b0;
        mrg_ctl.start = 1'b0;
        mrg_ctl.take  = 1'b0;
        case (r_state)
            T_IDLE: begin
                // No beat is taken while reset is held.
                i_in.ready = i_rst_n;
                if (i_in.valid && i_rst_n) begin
                    lane_start = 1'b1;
                    n_state    = T_LANES;
                end
            end
            T_LANES: begin
                if (lanes_done) begin
                    mrg_ctl.start = 1'b1;
                    n_state       = T_MERGE;
                end
            end
            T_MERGE: begin
                if (mrg_done && (!r_out_valid || o_out.ready)) begin
                    mrg_ctl.take = 1'b1;
                    n_state      = T_IDLE;
                end
            end
            default: n_state = T_IDLE;
        endcase
    end

    // Output register holds the beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (mrg_ctl.take) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mrg_ctl.take) begin
            r_out_pos <= mrg_pos;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.position_x = r_out_pos[0];
    assign o_out.position_y = r_out_pos[1];
    assign o_out.position_z = r_out_pos[2];

    `IDR_ASSERT_IMP(a_out_from_merge, i_clk, i_rst_n, $rose(r_out_valid), $past(mrg_done), "output loaded without a finished merge")
    `IDR_ASSERT_NXT(a_accept_starts, i_clk, i_rst_n, accept, r_state == T_LANES, "accepted beat did not start the lanes")
    `IDR_ASSERT_IMP(a_take_when_done, i_clk, i_rst_n, mrg_ctl.take, mrg_done && lanes_done, "merge result taken before it was ready")

endmodule

### src/idr_axis_lane.sv
// ----------------------------------------------------------------------------
// idr_axis_lane
// One body axis: velocity update by accel * dt, then displacement v * dt.
// ----------------------------------------------------------------------------
module idr_axis_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [idr_pkg::ACC_W-1:0]  i_accel,
    input  logic [idr_pkg::DT_W-1:0]          i_dt,
    output logic                              o_done,
    output logic signed [idr_pkg::POS_W-1:0]  o_disp
);
    import idr_pkg::*;

    logic [1:0]               r_phase;
    logic                     r_busy;
    logic                     r_done;
    logic signed [56:0]       r_prod;
    logic signed [POS_W-1:0]  r_vel;
    logic [47:0]              r_lo_prod;
    logic signed [48:0]       r_hi_prod;
    logic signed [POS_W-1:0]  r_disp;

    logic signed [DT_W:0]     dt_s;
    logic signed [56:0]       prod;
    logic signed [56:0]       prod_rnd;
    logic signed [40:0]       dv;
    logic signed [55:0]       vsum;
    logic [47:0]              lo_prod;
    logic signed [48:0]       hi_prod;
    logic [48:0]              lo_rnd;
    logic signed [49:0]       disp_sum;

    // Arithmetic of the two products and their rounding.
    always_comb begin
        dt_s     = $signed({1'b0, i_dt});
        prod     = 57'(i_accel) * 57'(dt_s);
        prod_rnd = r_prod + 57'sd32768;
        dv       = prod_rnd[56:16];
        vsum     = 56'(r_vel) + 56'(dv);
        lo_prod  = 48'(r_vel[23:0]) * 48'(i_dt);
        hi_prod  = 49'($signed(r_vel[47:24])) * 49'(dt_s);
        lo_rnd   = {1'b0, r_lo_prod} + 49'd8388608;
        disp_sum = 50'(r_hi_prod) + $signed({25'd0, lo_rnd[48:24]});
    end

    // Four-step sequence: product, velocity, split products, displacement.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_vel   <= '0;
        end else if (i_start) begin
            r_prod  <= prod;
            r_phase <= 2'd1;
            r_busy  <= 1'b1;
            r_done  <= 1'b0;
        end else if (r_busy) begin
            case (r_phase)
                2'd1: begin
                    r_vel   <= sat48(vsum);
                    r_phase <= 2'd2;
                end
                2'd2: begin
                    r_lo_prod <= lo_prod;
                    r_hi_prod <= hi_prod;
                    r_phase   <= 2'd3;
                end
                2'd3: begin
                    r_disp <= disp_sum[POS_W-1:0];
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                default: r_phase <= 2'd1;
            endcase
        end
    end

    assign o_done = r_done;
    assign o_disp = r_disp;

endmodule

### src/idr_cordic_lane.sv
// ----------------------------------------------------------------------------
// idr_cordic_lane
// Sine and cosine of one angle by sixteen rotation-mode CORDIC iterations.
// ----------------------------------------------------------------------------
module idr_cordic_lane (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [idr_pkg::ANG_W-1:0]  i_angle,
    output logic                              o_done,
    output idr_pkg::t_sincos                  o_sc
);
    import idr_pkg::*;

    logic                    r_busy;
    logic                    r_done;
    logic [3:0]              r_i;
    logic                    r_flip;
    logic signed [CS_W-1:0]  r_x;
    logic signed [CS_W-1:0]  r_y;
    logic signed [Z_W-1:0]   r_z;

    logic signed [Z_W-1:0]   z0;
    logic signed [Z_W-1:0]   z_red;
    logic                    flip;
    logic signed [CS_W-1:0]  dx;
    logic signed [CS_W-1:0]  dy;
    logic signed [Z_W-1:0]   at;

    // Range reduction into [-pi/2, pi/2] and one iteration step.
    always_comb begin
        z0 = $signed({{2{i_angle[ANG_W-1]}}, i_angle, 3'b000});
        if (z0 > HALF_PI_Q16) begin
            z_red = z0 - PI_Q16;
            flip  = 1'b1;
        end else if (z0 < -HALF_PI_Q16) begin
            z_red = z0 + PI_Q16;
            flip  = 1'b1;
        end else begin
            z_red = z0;
            flip  = 1'b0;
        end
        dx = r_y >>> r_i;
        dy = r_x >>> r_i;
        at = atan_q16(r_i);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= '0;
        end else if (i_start) begin
            r_x    <= CORDIC_GAIN;
            r_y    <= '0;
            r_z    <= z_red;
            r_flip <= flip;
            r_i    <= '0;
            r_busy <= 1'b1;
            r_done <= 1'b0;
        end else if (r_busy) begin
            if (r_z >= 0) begin
                r_x <= r_x - dx;
                r_y <= r_y + dy;
                r_z <= r_z - at;
            end else begin
                r_x <= r_x + dx;
                r_y <= r_y - dy;
                r_z <= r_z + at;
            end
            r_i <= r_i + 4'd1;
            if (r_i == 4'd15) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // Undo the half-turn reduction by negating both results.
    always_comb begin
        o_sc.cos_v = r_flip ? -r_x : r_x;
        o_sc.sin_v = r_flip ? -r_y : r_y;
    end

    assign o_done = r_done;

endmodule

### src/idr_merge.sv
// ----------------------------------------------------------------------------
// idr_merge
// Builds the Z-Y-X rotation matrix from the lane results, rotates the
// displacement into the world frame and accumulates the kept position.
// ----------------------------------------------------------------------------
module idr_merge (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  idr_pkg::t_mrg_ctl                 i_ctl,
    input  logic signed [idr_pkg::POS_W-1:0]  i_disp [3],
    input  idr_pkg::t_sincos                  i_yaw,
    input  idr_pkg::t_sincos                  i_pitch,
    input  idr_pkg::t_sincos                  i_roll,
    output logic                              o_done,
    output logic signed [idr_pkg::POS_W-1:0]  o_pos [3]
);
    import idr_pkg::*;

    t_mrg_state               r_state;
    t_mrg_state               n_state;
    logic [3:0]               r_k;
    logic [1:0]               r_row;
    logic [1:0]               r_col;
    logic signed [MAT_W-1:0]  r_p [NPROD];
    logic signed [MAT_W-1:0]  r_m [NMAT];
    logic signed [58:0]       r_lo_prod;
    logic signed [57:0]       r_hi_prod;
    logic signed [54:0]       r_acc;
    logic signed [POS_W-1:0]  r_pos [3];

    logic signed [MAT_W-1:0]  cy, sy, cp, sp, cr, sr;
    logic signed [MAT_W-1:0]  opa;
    logic signed [MAT_W-1:0]  opb;
    logic signed [67:0]       mprod;
    logic signed [67:0]       mrnd;
    logic signed [MAT_W-1:0]  mres;
    logic [3:0]               e_idx;
    logic signed [POS_W-1:0]  a_in;
    logic signed [MAT_W-1:0]  b_in;
    logic signed [58:0]       lo_rnd;
    logic signed [58:0]       wsum;
    logic signed [52:0]       term;
    logic signed [54:0]       acc_n;

    // Operand selection for the shared Q2.30 multiplier, one product a step.
    always_comb begin
        cy = MAT_W'(i_yaw.cos_v);
        sy = MAT_W'(i_yaw.sin_v);
        cp = MAT_W'(i_pitch.cos_v);
        sp = MAT_W'(i_pitch.sin_v);
        cr = MAT_W'(i_roll.cos_v);
        sr = MAT_W'(i_roll.sin_v);
        case (r_k)
            4'd0:    begin opa = cy;     opb = sp; end
            4'd1:    begin opa = sy;     opb = sp; end
            4'd2:    begin opa = cy;     opb = cp; end
            4'd3:    begin opa = r_p[0]; opb = sr; end
            4'd4:    begin opa = sy;     opb = cr; end
            4'd5:    begin opa = r_p[0]; opb = cr; end
            4'd6:    begin opa = sy;     opb = sr; end
            4'd7:    begin opa = sy;     opb = cp; end
            4'd8:    begin opa = r_p[1]; opb = sr; end
            4'd9:    begin opa = cy;     opb = cr; end
            4'd10:   begin opa = r_p[1]; opb = cr; end
            4'd11:   begin opa = cy;     opb = sr; end
            4'd12:   begin opa = cp;     opb = sr; end
            4'd13:   begin opa = cp;     opb = cr; end
            default: begin opa = '0;     opb = '0; end
        endcase
        mprod = 68'(opa) * 68'(opb);
        mrnd  = mprod + (68'sd1 <<< 29);
        mres  = mrnd[63:30];
    end

    // Rotation term: displacement times matrix entry, split at bit 24.
    always_comb begin
        e_idx  = 4'(r_row) * 4'd3 + 4'(r_col);
        a_in   = i_disp[r_col];
        b_in   = r_m[e_idx];
        lo_rnd = r_lo_prod + (59'sd1 <<< 29);
        wsum   = 59'(r_hi_prod) + 59'($signed(lo_rnd[58:24]));
        term   = wsum[58:6];
        acc_n  = r_acc + 55'(term);
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and outputs.
    always_comb begin
        n_state = r_state;
        o_done  = 1'b0;
        case (r_state)
            M_IDLE: begin
                if (i_ctl.start) begin
                    n_state = M_MAT;
                end
            end
            M_MAT: begin
                if (r_k == 4'(NPROD - 1)) begin
                    n_state = M_SUM;
                end
            end
            M_SUM:   n_state = M_ROT_A;
            M_ROT_A: n_state = M_ROT_B;
            M_ROT_B: begin
                if (r_col == 2'd2 && r_row == 2'd2) begin
                    n_state = M_DONE;
                end else begin
                    n_state = M_ROT_A;
                end
            end
            M_DONE: begin
                o_done = 1'b1;
                if (i_ctl.take) begin
                    n_state = M_IDLE;
                end
            end
            default: n_state = M_IDLE;
        endcase
    end

    // Kept world position.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos[0] <= '0;
            r_pos[1] <= '0;
            r_pos[2] <= '0;
        end else if (r_state == M_ROT_B && r_col == 2'd2) begin
            r_pos[r_row] <= sat48(56'(r_pos[r_row]) + 56'(acc_n));
        end
    end

    // Datapath: products, matrix assembly and rotation accumulation.
    always_ff @(posedge i_clk) begin
        case (r_state)
            M_IDLE: begin
                r_k <= '0;
            end
            M_MAT: begin
                r_p[r_k] <= mres;
                r_k      <= r_k + 4'd1;
            end
            M_SUM: begin
                r_m[0] <= r_p[2];
                r_m[1] <= r_p[3] - r_p[4];
                r_m[2] <= r_p[5] + r_p[6];
                r_m[3] <= r_p[7];
                r_m[4] <= r_p[8] + r_p[9];
                r_m[5] <= r_p[10] - r_p[11];
                r_m[6] <= -sp;
                r_m[7] <= r_p[12];
                r_m[8] <= r_p[13];
                r_row  <= '0;
                r_col  <= '0;
                r_acc  <= '0;
            end
            M_ROT_A: begin
                r_lo_prod <= 59'($signed({1'b0, a_in[23:0]})) * 59'(b_in);
                r_hi_prod <= 58'($signed(a_in[47:24])) * 58'(b_in);
            end
            M_ROT_B: begin
                if (r_col == 2'd2) begin
                    r_acc <= '0;
                    r_col <= '0;
                    r_row <= r_row + 2'd1;
                end else begin
                    r_acc <= acc_n;
                    r_col <= r_col + 2'd1;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_pos = r_pos;

endmodule
